// File: rtl/idr_pkg.sv
// Package for the integer divide/remainder unit: operation codes, widths,
// identifier defaults and the structs that travel down the divider chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package idr_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned OP_W      = 2;

  // Default identifier space sizes
  localparam int unsigned PHYS_REGS_DEF = 64;
  localparam int unsigned ROB_DEPTH_DEF = 64;
  localparam int unsigned TAG_COUNT_DEF = 256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_DIV  = 2'd0;
  localparam logic [OP_W-1:0] OP_DIVU = 2'd1;
  localparam logic [OP_W-1:0] OP_REM  = 2'd2;
  localparam logic [OP_W-1:0] OP_REMU = 2'd3;

  // Result fix-up flags carried alongside the arithmetic
  typedef struct packed {
    logic is_rem;
    logic neg_q;
    logic neg_r;
  } idr_flags_t;

  localparam int unsigned FLAGS_W = $bits(idr_flags_t);

  // Working state of one divider step: partial remainder, dividend bits
  // shifting out at the top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dq;
    logic [DATA_W-1:0] divisor;
  } idr_data_t;

endpackage : idr_pkg

`default_nettype wire

// File: rtl/idr_pre.sv
// Operand conditioning stage: decodes the operation, takes magnitudes of
// signed operands and records the sign fix-up. Uses idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idr_pre
  import idr_pkg::*;
#(
  parameter int unsigned ID_W = 20
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [DATA_W-1:0] in_dividend,
  input  wire logic [DATA_W-1:0] in_divisor,
  input  wire logic [ID_W-1:0]   in_ids,
  output logic                   out_valid,
  output idr_data_t              out_data,
  output logic [FLAGS_W+ID_W-1:0] out_sb
);

  logic                    valid_r;
  idr_data_t               data_r,  data_nxt;
  idr_flags_t              flags_r, flags_nxt;
  logic [ID_W-1:0]         ids_r;

  logic is_signed;
  logic neg_a;
  logic neg_b;
  logic div_zero;

  always_comb begin
    is_signed = (in_op == OP_DIV) || (in_op == OP_REM);
    neg_a     = is_signed && in_dividend[DATA_W-1];
    neg_b     = is_signed && in_divisor[DATA_W-1];
    div_zero  = (in_divisor == '0);

    data_nxt.rem     = '0;
    data_nxt.dq      = neg_a ? (~in_dividend + 1'b1) : in_dividend;
    data_nxt.divisor = neg_b ? (~in_divisor + 1'b1) : in_divisor;

    flags_nxt.is_rem = (in_op == OP_REM) || (in_op == OP_REMU);
    // a zero divisor leaves the all-ones quotient unsigned-looking
    flags_nxt.neg_q  = (neg_a ^ neg_b) && !div_zero;
    flags_nxt.neg_r  = neg_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    flags_r <= flags_nxt;
    ids_r   <= in_ids;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_sb    = {flags_r, ids_r};

endmodule : idr_pre

`default_nettype wire

// File: rtl/idr_cell.sv
// One cell of the divider chain: a single restoring step producing one
// quotient bit, with the sideband shifted along. Uses idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idr_cell
  import idr_pkg::*;
#(
  parameter int unsigned SB_W = 23
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire idr_data_t       in_data,
  input  wire logic [SB_W-1:0] in_sb,
  output logic                 out_valid,
  output idr_data_t            out_data,
  output logic [SB_W-1:0]      out_sb
);

  logic              valid_r;
  idr_data_t         data_r, data_nxt;
  logic [SB_W-1:0]   sb_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;
  logic              borrow;

  always_comb begin
    shifted = {in_data.rem, in_data.dq[DATA_W-1]};
    diff    = {1'b0, shifted} - {2'b00, in_data.divisor};
    borrow  = diff[DATA_W+1];

    data_nxt.rem     = borrow ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
    data_nxt.dq      = {in_data.dq[DATA_W-2:0], ~borrow};
    data_nxt.divisor = in_data.divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    sb_r   <= in_sb;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_sb    = sb_r;

endmodule : idr_cell

`default_nettype wire

// File: rtl/idr_post.sv
// Result stage: picks quotient or remainder and applies the sign fix-up.
// Uses idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idr_post
  import idr_pkg::*;
#(
  parameter int unsigned ID_W = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire idr_data_t               in_data,
  input  wire logic [FLAGS_W+ID_W-1:0] in_sb,
  output logic                         out_valid,
  output logic [DATA_W-1:0]            out_result,
  output logic [ID_W-1:0]              out_ids
);

  logic              valid_r;
  logic [DATA_W-1:0] result_r, result_nxt;
  logic [ID_W-1:0]   ids_r;

  idr_flags_t        flags;
  logic [DATA_W-1:0] mag;
  logic              negate;

  always_comb begin
    flags      = in_sb[FLAGS_W+ID_W-1:ID_W];
    mag        = flags.is_rem ? in_data.rem : in_data.dq;
    negate     = flags.is_rem ? flags.neg_r : flags.neg_q;
    result_nxt = negate ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    ids_r    <= in_sb[ID_W-1:0];
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;
  assign out_ids    = ids_r;

endmodule : idr_post

`default_nettype wire

// File: rtl/integer_divide_remainder_unit_core.sv
// An accepted start is registered in the pre stage, each divider cell and the post stage before out_valid.
// Throughput: one transaction per cycle; 32 chained divider cells, one quotient bit each.
// busy is low whenever rst_n is high; the receiver cannot stall the result strobe.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_divide_remainder_unit_core
  import idr_pkg::*;
#(
  parameter int unsigned PHYS_REGS = PHYS_REGS_DEF,
  parameter int unsigned ROB_DEPTH = ROB_DEPTH_DEF,
  parameter int unsigned TAG_COUNT = TAG_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [OP_W-1:0]              in_operation,
  input  wire logic [DATA_W-1:0]            in_dividend,
  input  wire logic [DATA_W-1:0]            in_divisor,
  input  wire logic [$clog2(TAG_COUNT)-1:0] in_producer_tag,
  input  wire logic [$clog2(PHYS_REGS)-1:0] in_dest_register,
  input  wire logic [$clog2(ROB_DEPTH)-1:0] in_rob_index,
  output logic                              out_valid,
  output logic [DATA_W-1:0]                 out_quotient_or_remainder,
  output logic [$clog2(TAG_COUNT)-1:0]      out_result_tag,
  output logic [$clog2(PHYS_REGS)-1:0]      out_write_register,
  output logic [$clog2(ROB_DEPTH)-1:0]      out_ready_rob_index
);

  localparam int unsigned TAG_W = $clog2(TAG_COUNT);
  localparam int unsigned REG_W = $clog2(PHYS_REGS);
  localparam int unsigned ROB_W = $clog2(ROB_DEPTH);
  localparam int unsigned ID_W  = TAG_W + REG_W + ROB_W;
  localparam int unsigned SB_W  = FLAGS_W + ID_W;
  // pre stage, one register per cell, post stage
  localparam int unsigned LAT   = DIV_STEPS + 2;

  logic              accept;
  logic [ID_W-1:0]   in_ids;
  logic [ID_W-1:0]   out_ids;

  logic              stage_valid [DIV_STEPS+1];
  idr_data_t         stage_data  [DIV_STEPS+1];
  logic [SB_W-1:0]   stage_sb    [DIV_STEPS+1];

  assign busy   = !rst_n;
  assign accept = start && !busy;
  assign in_ids = {in_producer_tag, in_dest_register, in_rob_index};

  idr_pre #(
    .ID_W (ID_W)
  ) u_pre (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .in_op       (in_operation),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .in_ids      (in_ids),
    .out_valid   (stage_valid[0]),
    .out_data    (stage_data[0]),
    .out_sb      (stage_sb[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    idr_cell #(
      .SB_W (SB_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_valid[i]),
      .in_data   (stage_data[i]),
      .in_sb     (stage_sb[i]),
      .out_valid (stage_valid[i+1]),
      .out_data  (stage_data[i+1]),
      .out_sb    (stage_sb[i+1])
    );
  end

  idr_post #(
    .ID_W (ID_W)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stage_valid[DIV_STEPS]),
    .in_data    (stage_data[DIV_STEPS]),
    .in_sb      (stage_sb[DIV_STEPS]),
    .out_valid  (out_valid),
    .out_result (out_quotient_or_remainder),
    .out_ids    (out_ids)
  );

  assign out_result_tag      = out_ids[ID_W-1:REG_W+ROB_W];
  assign out_write_register  = out_ids[REG_W+ROB_W-1:ROB_W];
  assign out_ready_rob_index = out_ids[ROB_W-1:0];

`ifndef SYNTH
  // every accepted transaction comes out as a result strobe at the end of the chain
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("result strobe missing after accepted transaction");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching transaction");

  // last cell must leave a fully reduced remainder
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid[DIV_STEPS] && (stage_data[DIV_STEPS].divisor != '0))
      |-> (stage_data[DIV_STEPS].rem < stage_data[DIV_STEPS].divisor))
    else $error("partial remainder not below divisor at end of chain");

  a_div_zero_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid[DIV_STEPS] && (stage_data[DIV_STEPS].divisor == '0))
      |-> (stage_data[DIV_STEPS].dq == '1))
    else $error("divide by zero did not give all-ones quotient");
`endif

endmodule : integer_divide_remainder_unit_core

`default_nettype wire
